[rtl/b2da_pkg.sv]
`default_nettype none

package b2da_pkg;

  localparam int VALUE_W        = 16;
  localparam int COUNT_W        = 8;
  localparam int DIGIT_W        = 4;
  localparam int CHAR_W         = 6;
  localparam int MAX_DIGITS_DEF = 5;

  // x / 10 == (x * 0xCCCD) >> 19 for every 16-bit x
  localparam logic [VALUE_W-1:0] DIV10_MUL   = 16'hCCCD;
  localparam int                 DIV10_SHIFT = 19;

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'h30;

  typedef struct packed {
    logic [COUNT_W-1:0] digit_count;
    logic [VALUE_W-1:0] value;
  } conv_t;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
  } text_t;

endpackage

`default_nettype wire

[rtl/binary_to_decimal_ascii.sv]
`default_nettype none

// Converts a 16-bit unsigned value into its lowest N decimal digits as ASCII
// '0'..'9', most significant first, one character per output item; N is the
// requested count clamped to MAX_DIGITS, and the final character carries last.
// A count of zero produces no output. A row of MAX_DIGITS divide-by-ten cells
// peels one digit per cell and hands the quotient on each cycle, so a new item
// can be taken every cycle unless the output channel stalls the row.
// Throughput is set by the output channel: an item of N digits holds it until
// all N characters are taken, the next item loads as the last one is taken,
// and the row keeps filling behind it.
module binary_to_decimal_ascii #(
  parameter int MAX_DIGITS = b2da_pkg::MAX_DIGITS_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            conv_valid,
  output logic                 conv_ready,
  input  wire b2da_pkg::conv_t conv,
  output logic                 text_valid,
  input  wire logic            text_ready,
  output b2da_pkg::text_t      text
);

  localparam int CNT_W = $clog2(MAX_DIGITS + 1);
  localparam int VW    = b2da_pkg::VALUE_W;
  localparam int DW    = b2da_pkg::DIGIT_W;

  logic                     lnk_valid  [MAX_DIGITS+1];
  logic                     lnk_ready  [MAX_DIGITS+1];
  logic [VW-1:0]            lnk_rest   [MAX_DIGITS+1];
  logic [CNT_W-1:0]         lnk_count  [MAX_DIGITS+1];
  logic [MAX_DIGITS*DW-1:0] lnk_digits [MAX_DIGITS+1];

  assign lnk_valid[0]  = conv_valid;
  assign conv_ready    = lnk_ready[0];
  assign lnk_rest[0]   = conv.value;
  assign lnk_count[0]  = (conv.digit_count > b2da_pkg::COUNT_W'(MAX_DIGITS))
                       ? CNT_W'(MAX_DIGITS) : conv.digit_count[CNT_W-1:0];
  assign lnk_digits[0] = '0;

  for (genvar g = 0; g < MAX_DIGITS; g++) begin : g_cell
    b2da_cell #(
      .MAX_DIGITS (MAX_DIGITS),
      .INDEX      (g),
      .CNT_W      (CNT_W)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .up_valid  (lnk_valid[g]),
      .up_ready  (lnk_ready[g]),
      .up_rest   (lnk_rest[g]),
      .up_count  (lnk_count[g]),
      .up_digits (lnk_digits[g]),
      .dn_valid  (lnk_valid[g+1]),
      .dn_ready  (lnk_ready[g+1]),
      .dn_rest   (lnk_rest[g+1]),
      .dn_count  (lnk_count[g+1]),
      .dn_digits (lnk_digits[g+1])
    );
  end

  b2da_emit #(
    .MAX_DIGITS (MAX_DIGITS),
    .CNT_W      (CNT_W)
  ) u_emit (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (lnk_valid[MAX_DIGITS]),
    .up_ready   (lnk_ready[MAX_DIGITS]),
    .up_count   (lnk_count[MAX_DIGITS]),
    .up_digits  (lnk_digits[MAX_DIGITS]),
    .text_valid (text_valid),
    .text_ready (text_ready),
    .text       (text)
  );

endmodule

`default_nettype wire

[rtl/b2da_cell.sv]
`default_nettype none

module b2da_cell #(
  parameter int MAX_DIGITS = b2da_pkg::MAX_DIGITS_DEF,
  parameter int INDEX      = 0,
  parameter int CNT_W      = $clog2(MAX_DIGITS + 1)
) (
  input  wire logic                                        clk,
  input  wire logic                                        rst,
  input  wire logic                                        up_valid,
  output logic                                             up_ready,
  input  wire logic [b2da_pkg::VALUE_W-1:0]                up_rest,
  input  wire logic [CNT_W-1:0]                            up_count,
  input  wire logic [MAX_DIGITS*b2da_pkg::DIGIT_W-1:0]     up_digits,
  output logic                                             dn_valid,
  input  wire logic                                        dn_ready,
  output logic [b2da_pkg::VALUE_W-1:0]                     dn_rest,
  output logic [CNT_W-1:0]                                 dn_count,
  output logic [MAX_DIGITS*b2da_pkg::DIGIT_W-1:0]          dn_digits
);

  localparam int VW = b2da_pkg::VALUE_W;
  localparam int DW = b2da_pkg::DIGIT_W;

  logic [2*VW-1:0]              prod;
  logic [VW-1:0]                quot;
  logic [VW-1:0]                quot_x10;
  logic [VW-1:0]                rem;
  logic [MAX_DIGITS*DW-1:0]     digits_next;

  always_comb begin
    prod        = {{VW{1'b0}}, up_rest} * {{VW{1'b0}}, b2da_pkg::DIV10_MUL};
    quot        = VW'(prod >> b2da_pkg::DIV10_SHIFT);
    quot_x10    = VW'({quot, 3'b000}) + VW'({quot, 1'b0});
    rem         = up_rest - quot_x10;
    digits_next = up_digits;
    digits_next[INDEX*DW +: DW] = rem[DW-1:0];
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      dn_rest   <= quot;
      dn_count  <= up_count;
      dn_digits <= digits_next;
    end
  end

endmodule

`default_nettype wire

[rtl/b2da_emit.sv]
`default_nettype none

module b2da_emit #(
  parameter int MAX_DIGITS = b2da_pkg::MAX_DIGITS_DEF,
  parameter int CNT_W      = $clog2(MAX_DIGITS + 1)
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    up_valid,
  output logic                                         up_ready,
  input  wire logic [CNT_W-1:0]                        up_count,
  input  wire logic [MAX_DIGITS*b2da_pkg::DIGIT_W-1:0] up_digits,
  output logic                                         text_valid,
  input  wire logic                                    text_ready,
  output b2da_pkg::text_t                              text
);

  localparam int DW    = b2da_pkg::DIGIT_W;
  localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  logic [MAX_DIGITS*DW-1:0] digits;
  logic [IDX_W-1:0]         pos;
  logic                     load;
  logic                     done;

  assign done     = text_valid && text_ready && (pos == '0);
  assign up_ready = !text_valid || done;
  assign load     = up_valid && up_ready && (up_count != '0);

  assign text.character = b2da_pkg::ASCII_ZERO
                        + b2da_pkg::CHAR_W'(digits[pos*DW +: DW]);
  assign text.last      = (pos == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      text_valid <= 1'b0;
    end else if (load) begin
      text_valid <= 1'b1;
    end else if (done) begin
      text_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      digits <= up_digits;
      pos    <= IDX_W'(up_count - CNT_W'(1));
    end else if (text_valid && text_ready) begin
      pos    <= pos - IDX_W'(1);
    end
  end

  a_drop_after_last: assert property (@(posedge clk) disable iff (rst)
    done && !load |=> !text_valid)
    else $error("emitter still busy after last item");

  a_step_down: assert property (@(posedge clk) disable iff (rst)
    text_valid && text_ready && !text.last |=> text_valid && pos == $past(pos) - IDX_W'(1))
    else $error("digit position did not advance");

  a_load_pos: assert property (@(posedge clk) disable iff (rst)
    load |=> text_valid && pos == $past(IDX_W'(up_count - CNT_W'(1))))
    else $error("digit position wrong after load");

  a_no_zero_load: assert property (@(posedge clk) disable iff (rst)
    up_valid && up_ready && up_count == '0 && !text_valid |=> !text_valid)
    else $error("empty item produced output");

endmodule

`default_nettype wire
